@@ rtl/dxtd_pkg.sv @@
// ----------------------------------------------------------------------------
// DXT block texel decoder package
// Shared types and constants for the block texel decoder: the input and
// result items, the per-block palette and the configuration register map.
// ----------------------------------------------------------------------------
package dxtd_pkg;

    // Largest image side in texels, and the widths that follow from it.
    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;   // configured width / height
    localparam int COORD_W       = 12;   // texel coordinate
    localparam int BLK_W         = 10;   // block column / row
    localparam int BCNT_W        = 11;   // block count per row / column

    // Configuration register indexes.
    localparam logic [1:0] REG_ALPHA_MODE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Alpha modes.
    localparam logic [1:0] MODE_DXT1 = 2'd0;   // colour-key alpha
    localparam logic [1:0] MODE_DXT3 = 2'd1;   // explicit nibble alpha
    localparam logic [1:0] MODE_DXT5 = 2'd2;   // interpolated alpha

    typedef struct packed {
        logic [63:0] color_word;
        logic [63:0] alpha_word;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] texel_x;
        logic [COORD_W-1:0] texel_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               last_of_block;
        logic               last_of_image;
    } t_out_item;

    // Decoded palettes of one block.
    typedef struct packed {
        logic [3:0][7:0] red;
        logic [3:0][7:0] green;
        logic [3:0][7:0] blue;
        logic            key3;    // colour index three is transparent black
        logic [7:0][7:0] atab;    // interpolated alpha table
    } t_palette;

endpackage

@@ rtl/dxtd_palette.sv @@
// ----------------------------------------------------------------------------
// DXT palette builder
// Expands the two RGB565 end points, interpolates the colour palette and
// builds the eight-entry interpolated alpha table of one block.
// ----------------------------------------------------------------------------
module dxtd_palette (
    input  logic [31:0]       i_colors,
    input  logic [15:0]       i_alphas,
    input  logic [1:0]        i_mode,
    output dxtd_pkg::t_palette o_palette
);
    import dxtd_pkg::*;

    // Truncating division by small constants as multiplication by a
    // reciprocal; each is exact over the range of sums that can occur here.
    function automatic logic [7:0] f_div3(input logic [9:0] v);
        logic [19:0] p;
        p = 20'(v) * 20'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] f_div5(input logic [10:0] v);
        logic [21:0] p;
        p = 22'(v) * 22'd3277;
        return p[21:14];
    endfunction

    function automatic logic [7:0] f_div7(input logic [10:0] v);
        logic [22:0] p;
        p = 23'(v) * 23'd2341;
        return p[21:14];
    endfunction

    logic [15:0]     c0;
    logic [15:0]     c1;
    logic [2:0][7:0] e0;   // red, green, blue of end point zero
    logic [2:0][7:0] e1;
    logic [2:0][7:0] p2;
    logic [2:0][7:0] p3;
    logic            key;
    logic [7:0]      a0;
    logic [7:0]      a1;
    logic [10:0]     s7;
    logic [10:0]     s5;
    logic [8:0]      s2;
    logic [7:0][7:0] atab;

    assign c0  = i_colors[15:0];
    assign c1  = i_colors[31:16];
    assign key = (i_mode == MODE_DXT1) && (c0 <= c1);

    always_comb begin
        e0[2] = {c0[15:11], c0[15:13]};
        e0[1] = {c0[10:5],  c0[10:9]};
        e0[0] = {c0[4:0],   c0[4:2]};
        e1[2] = {c1[15:11], c1[15:13]};
        e1[1] = {c1[10:5],  c1[10:9]};
        e1[0] = {c1[4:0],   c1[4:2]};
        for (int k = 0; k < 3; k++) begin
            s2 = 9'(e0[k]) + 9'(e1[k]);
            if (key) begin
                p2[k] = s2[8:1];
                p3[k] = 8'd0;
            end else begin
                p2[k] = f_div3(10'({e0[k], 1'b0}) + 10'(e1[k]));
                p3[k] = f_div3(10'(e0[k]) + 10'({e1[k], 1'b0}));
            end
        end
    end

    assign a0 = i_alphas[7:0];
    assign a1 = i_alphas[15:8];

    always_comb begin
        s7 = '0;
        s5 = '0;
        atab[0] = a0;
        atab[1] = a1;
        for (int k = 2; k < 8; k++) begin
            atab[k] = 8'd0;
        end
        if (a0 > a1) begin
            for (int k = 1; k < 7; k++) begin
                s7 = 11'(a0) * 11'(7 - k) + 11'(a1) * 11'(k);
                atab[k + 1] = f_div7(s7);
            end
        end else begin
            for (int k = 1; k < 5; k++) begin
                s5 = 11'(a0) * 11'(5 - k) + 11'(a1) * 11'(k);
                atab[k + 1] = f_div5(s5);
            end
            atab[6] = 8'd0;
            atab[7] = 8'd255;
        end
    end

    always_comb begin
        o_palette.red   = {p3[2], p2[2], e1[2], e0[2]};
        o_palette.green = {p3[1], p2[1], e1[1], e0[1]};
        o_palette.blue  = {p3[0], p2[0], e1[0], e0[0]};
        o_palette.key3  = key;
        o_palette.atab  = atab;
    end

endmodule

@@ rtl/dxt_block_texel_decoder.sv @@
// ----------------------------------------------------------------------------
// DXT block texel decoder
// Decodes DXT1, DXT3 and DXT5 compressed 4x4 blocks into RGBA8 texels with
// their image coordinates, walking the image block by block.
// ----------------------------------------------------------------------------
// Each input item is one compressed block; the block produces one result
// item per texel that lies inside the configured image, in raster order
// within the block, one texel per clock cycle while the output is not
// stalled. Blocks follow one another with no gap, and a block entirely
// outside the image produces nothing. The rate is set by the texel walker,
// which hands one texel a cycle to the output register when that register
// is free. The path is three registers deep: an input register, the texel
// walker (which holds the palettes built from the input register) and the
// output register. A new block is accepted while the previous one is still
// being walked. The block position starts at the top-left block after
// reset, advances by one block for every item accepted and wraps to the
// origin after the last block of the image. Configuration (alpha mode,
// image width and height) may only be written while the decoder is idle;
// a width or height of zero counts as one and anything above 4096 counts
// as 4096.
module dxt_block_texel_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    // compressed blocks in
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dxtd_pkg::t_in_item   i_in,
    // texels out
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dxtd_pkg::t_out_item  o_out
);
    import dxtd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers and the derived image geometry.
    // ------------------------------------------------------------------
    logic [1:0]        r_alpha_mode;
    logic [DIM_W-1:0]  r_image_width;
    logic [DIM_W-1:0]  r_image_height;

    logic [DIM_W-1:0]  width_c;
    logic [DIM_W-1:0]  height_c;
    logic [BCNT_W-1:0] blocks_x;
    logic [BCNT_W-1:0] blocks_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_mode   <= MODE_DXT1;
            r_image_width  <= DIM_W'(1);
            r_image_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ALPHA_MODE:   r_alpha_mode   <= i_cfg_data[1:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Zero counts as one; anything above the largest side is saturated.
    always_comb begin
        width_c = r_image_width;
        if (r_image_width == '0) begin
            width_c = DIM_W'(1);
        end else if (r_image_width > DIM_W'(MAX_DIMENSION)) begin
            width_c = DIM_W'(MAX_DIMENSION);
        end
        height_c = r_image_height;
        if (r_image_height == '0) begin
            height_c = DIM_W'(1);
        end else if (r_image_height > DIM_W'(MAX_DIMENSION)) begin
            height_c = DIM_W'(MAX_DIMENSION);
        end
    end

    assign blocks_x = BCNT_W'((width_c + DIM_W'(3)) >> 2);
    assign blocks_y = BCNT_W'((height_c + DIM_W'(3)) >> 2);

    // ------------------------------------------------------------------
    // Handshake between the three stages.
    // ------------------------------------------------------------------
    logic r_in_valid;
    logic r_wk_valid;
    logic r_out_valid;
    logic in_take;     // item accepted at the port
    logic wk_step;     // walker hands a texel to the output register
    logic wk_last;     // the texel being handed over ends the block
    logic wk_free;     // walker can take a new block this cycle
    logic wk_load;     // block moves from the input register into the walker
    logic out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign wk_step     = r_wk_valid && out_free;
    assign wk_free     = !r_wk_valid || (wk_step && wk_last);
    assign wk_load     = r_in_valid && wk_free;
    assign o_in_ready  = !r_in_valid || wk_load;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Block position counter; the position travels with the item.
    // ------------------------------------------------------------------
    logic [BLK_W-1:0] r_blk_col;
    logic [BLK_W-1:0] r_blk_row;
    logic [BLK_W-1:0] n_blk_col;
    logic [BLK_W-1:0] n_blk_row;
    logic             at_final;

    assign at_final = ({1'b0, r_blk_col} == blocks_x - BCNT_W'(1))
                   && ({1'b0, r_blk_row} == blocks_y - BCNT_W'(1));

    always_comb begin
        n_blk_col = r_blk_col;
        n_blk_row = r_blk_row;
        if ({1'b0, r_blk_col} + BCNT_W'(1) >= blocks_x) begin
            n_blk_col = '0;
            if ({1'b0, r_blk_row} + BCNT_W'(1) >= blocks_y) begin
                n_blk_row = '0;
            end else begin
                n_blk_row = r_blk_row + BLK_W'(1);
            end
        end else begin
            n_blk_col = r_blk_col + BLK_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    t_in_item         r_in;
    logic [BLK_W-1:0] r_in_col;
    logic [BLK_W-1:0] r_in_row;
    logic             r_in_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_blk_col  <= '0;
            r_blk_row  <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
                r_blk_col  <= n_blk_col;
                r_blk_row  <= n_blk_row;
            end else if (wk_load) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in       <= i_in;
            r_in_col   <= r_blk_col;
            r_in_row   <= r_blk_row;
            r_in_final <= at_final;
        end
    end

    // ------------------------------------------------------------------
    // Palettes and the visible extent of the block in the input register.
    // ------------------------------------------------------------------
    t_palette         pal;
    logic [DIM_W-1:0] cols_left;
    logic [DIM_W-1:0] rows_left;
    logic [2:0]       vis_cols;
    logic [2:0]       vis_rows;

    dxtd_palette u_palette (
        .i_colors  (r_in.color_word[31:0]),
        .i_alphas  (r_in.alpha_word[15:0]),
        .i_mode    (r_alpha_mode),
        .o_palette (pal)
    );

    // A block partly or wholly outside the image keeps only the texels
    // inside it; a block entirely outside (after the size was reduced)
    // has no visible column or row and is dropped.
    always_comb begin
        cols_left = '0;
        rows_left = '0;
        if (width_c > DIM_W'({r_in_col, 2'b00})) begin
            cols_left = width_c - DIM_W'({r_in_col, 2'b00});
        end
        if (height_c > DIM_W'({r_in_row, 2'b00})) begin
            rows_left = height_c - DIM_W'({r_in_row, 2'b00});
        end
        vis_cols = (cols_left >= DIM_W'(4)) ? 3'd4 : cols_left[2:0];
        vis_rows = (rows_left >= DIM_W'(4)) ? 3'd4 : rows_left[2:0];
    end

    // ------------------------------------------------------------------
    // Texel walker: steps across the visible texels of the block.
    // ------------------------------------------------------------------
    t_palette         r_wk_pal;
    logic [31:0]      r_wk_cidx;
    logic [63:0]      r_wk_aword;
    logic [1:0]       r_wk_mode;
    logic [BLK_W-1:0] r_wk_col;
    logic [BLK_W-1:0] r_wk_row;
    logic             r_wk_final;
    logic [2:0]       r_wk_vc;
    logic [2:0]       r_wk_vr;
    logic [1:0]       r_wk_lx;
    logic [1:0]       r_wk_ly;
    logic             row_end;

    assign row_end = ({1'b0, r_wk_lx} == r_wk_vc - 3'd1);
    assign wk_last = row_end && ({1'b0, r_wk_ly} == r_wk_vr - 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wk_valid <= 1'b0;
            r_wk_lx    <= '0;
            r_wk_ly    <= '0;
        end else begin
            if (wk_load) begin
                r_wk_valid <= (vis_cols != 3'd0) && (vis_rows != 3'd0);
                r_wk_lx    <= '0;
                r_wk_ly    <= '0;
            end else if (wk_step) begin
                if (wk_last) begin
                    r_wk_valid <= 1'b0;
                end
                if (row_end) begin
                    r_wk_lx <= '0;
                    r_wk_ly <= r_wk_ly + 2'd1;
                end else begin
                    r_wk_lx <= r_wk_lx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wk_load) begin
            r_wk_pal   <= pal;
            r_wk_cidx  <= r_in.color_word[63:32];
            r_wk_aword <= r_in.alpha_word;
            r_wk_mode  <= r_alpha_mode;
            r_wk_col   <= r_in_col;
            r_wk_row   <= r_in_row;
            r_wk_final <= r_in_final;
            r_wk_vc    <= vis_cols;
            r_wk_vr    <= vis_rows;
        end
    end

    // ------------------------------------------------------------------
    // Texel selection for the walker's current position.
    // ------------------------------------------------------------------
    logic [3:0] tex;
    logic [1:0] ci;
    logic [3:0] nib;
    logic [5:0] abit;
    logic [2:0] ai;
    logic [7:0] alpha_v;
    t_out_item  texel;

    assign tex  = {r_wk_ly, r_wk_lx};
    assign ci   = r_wk_cidx[{tex, 1'b0} +: 2];
    assign nib  = r_wk_aword[{tex, 2'b00} +: 4];
    assign abit = 6'd16 + 6'(tex) * 6'd3;
    assign ai   = r_wk_aword[abit +: 3];

    always_comb begin
        case (r_wk_mode)
            MODE_DXT1: alpha_v = (r_wk_pal.key3 && ci == 2'd3) ? 8'd0 : 8'd255;
            MODE_DXT3: alpha_v = {nib, nib};
            MODE_DXT5: alpha_v = r_wk_pal.atab[ai];
            default:   alpha_v = 8'd255;
        endcase
        texel.texel_x       = {r_wk_col, r_wk_lx};
        texel.texel_y       = {r_wk_row, r_wk_ly};
        texel.red           = r_wk_pal.red[ci];
        texel.green         = r_wk_pal.green[ci];
        texel.blue          = r_wk_pal.blue[ci];
        texel.alpha         = alpha_v;
        texel.last_of_block = wk_last;
        texel.last_of_image = wk_last && r_wk_final;
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= wk_step || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wk_step) begin
            r_out <= texel;
        end
    end

    assign o_out = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_wk_extent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wk_valid |-> (r_wk_vc != 3'd0) && (r_wk_vr != 3'd0)
                       && ({1'b0, r_wk_lx} < r_wk_vc) && ({1'b0, r_wk_ly} < r_wk_vr))
        else $error("texel walker outside the visible part of its block");

    a_wk_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wk_load && (vis_cols != 3'd0) && (vis_rows != 3'd0)
            |=> r_wk_valid && (r_wk_lx == 2'd0) && (r_wk_ly == 2'd0))
        else $error("walker did not start a loaded block at its first texel");

    a_image_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last_of_image |-> r_out.last_of_block)
        else $error("end of image flagged on a texel that does not end its block");

    a_in_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_wk_valid)
        else $error("input stalled with a free stage behind it");

endmodule

@@ verif/dxtd_scoreboard_pkg.sv @@
// ----------------------------------------------------------------------------
// Texel scoreboard for the DXT block texel decoder
// Decodes each accepted block on the testbench side, queues the texels it
// should produce and compares every texel leaving the decoder with the
// oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dxtd_scoreboard_pkg;

    import dxtd_pkg::*;

    localparam int PRINT_CAP = 25;

    class texel_scoreboard;

        logic [1:0]  mode;
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        int unsigned blk_col;
        int unsigned blk_row;
        t_out_item   texels_due[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned blocks;

        function new();
            mode       = MODE_DXT1;
            width_reg  = 13'd1;
            height_reg = 13'd1;
            blk_col    = 0;
            blk_row    = 0;
            errors     = 0;
            checked    = 0;
            blocks     = 0;
        endfunction

        function int pending();
            return texels_due.size();
        endfunction

        function void note_config(logic [1:0] index, logic [12:0] value);
            case (index)
                REG_ALPHA_MODE:   mode       = value[1:0];
                REG_IMAGE_WIDTH:  width_reg  = value;
                REG_IMAGE_HEIGHT: height_reg = value;
                default: ;
            endcase
        endfunction

        // Zero counts as one, anything past the largest side saturates.
        function int unsigned clamp_side(logic [12:0] value);
            if (value == 13'd0) return 1;
            if (value > MAX_DIMENSION) return MAX_DIMENSION;
            return value;
        endfunction

        function int unsigned widen5(logic [4:0] v);
            return {v, v[4:2]};
        endfunction

        function int unsigned widen6(logic [5:0] v);
            return {v, v[5:4]};
        endfunction

        // Works out the texels of one block and advances the block position.
        function void decode_block(t_in_item blk);
            int unsigned w, h, bw, bh, x, y, a, i;
            int unsigned pr[4], pg[4], pb[4], pa[4];
            int unsigned atab[8];
            logic [15:0] c0, c1;
            logic [1:0]  ci;
            bit          last_blk, have;
            t_out_item   t;

            w  = clamp_side(width_reg);
            h  = clamp_side(height_reg);
            bw = (w + 3) / 4;
            bh = (h + 3) / 4;
            last_blk = (blk_col == bw - 1) && (blk_row == bh - 1);
            c0 = blk.color_word[15:0];
            c1 = blk.color_word[31:16];
            blocks++;

            pr[0] = widen5(c0[15:11]); pg[0] = widen6(c0[10:5]); pb[0] = widen5(c0[4:0]);
            pr[1] = widen5(c1[15:11]); pg[1] = widen6(c1[10:5]); pb[1] = widen5(c1[4:0]);
            for (i = 0; i < 4; i++) pa[i] = 255;
            if (mode == MODE_DXT1 && c0 <= c1) begin
                pr[2] = (pr[0] + pr[1]) / 2;
                pg[2] = (pg[0] + pg[1]) / 2;
                pb[2] = (pb[0] + pb[1]) / 2;
                pr[3] = 0; pg[3] = 0; pb[3] = 0; pa[3] = 0;
            end else begin
                pr[2] = (2 * pr[0] + pr[1]) / 3;
                pg[2] = (2 * pg[0] + pg[1]) / 3;
                pb[2] = (2 * pb[0] + pb[1]) / 3;
                pr[3] = (pr[0] + 2 * pr[1]) / 3;
                pg[3] = (pg[0] + 2 * pg[1]) / 3;
                pb[3] = (pb[0] + 2 * pb[1]) / 3;
            end

            atab[0] = blk.alpha_word[7:0];
            atab[1] = blk.alpha_word[15:8];
            if (atab[0] > atab[1]) begin
                for (i = 1; i < 7; i++)
                    atab[i + 1] = ((7 - i) * atab[0] + i * atab[1]) / 7;
            end else begin
                for (i = 1; i < 5; i++)
                    atab[i + 1] = ((5 - i) * atab[0] + i * atab[1]) / 5;
                atab[6] = 0;
                atab[7] = 255;
            end

            // The last texel is held back so that its flags can be set.
            have = 1'b0;
            for (i = 0; i < 16; i++) begin
                x  = blk_col * 4 + (i % 4);
                y  = blk_row * 4 + (i / 4);
                ci = blk.color_word[32 + 2 * i +: 2];
                if (x < w && y < h) begin
                    case (mode)
                        MODE_DXT1: a = pa[ci];
                        MODE_DXT3: a = blk.alpha_word[4 * i +: 4] * 17;
                        MODE_DXT5: a = atab[blk.alpha_word[16 + 3 * i +: 3]];
                        default:   a = 255;
                    endcase
                    if (have) texels_due.push_back(t);
                    t.texel_x       = x[COORD_W-1:0];
                    t.texel_y       = y[COORD_W-1:0];
                    t.red           = pr[ci][7:0];
                    t.green         = pg[ci][7:0];
                    t.blue          = pb[ci][7:0];
                    t.alpha         = a[7:0];
                    t.last_of_block = 1'b0;
                    t.last_of_image = 1'b0;
                    have = 1'b1;
                end
            end
            if (have) begin
                t.last_of_block = 1'b1;
                t.last_of_image = last_blk;
                texels_due.push_back(t);
            end

            if (blk_col + 1 >= bw) begin
                blk_col = 0;
                if (blk_row + 1 >= bh) blk_row = 0;
                else blk_row++;
            end else begin
                blk_col++;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
        endtask

        task compare_field(string field, logic [31:0] got_v, logic [31:0] want_v,
                           t_out_item want);
            if (got_v !== want_v)
                report($sformatf("texel (%0d,%0d) %s: got %0h, expected %0h",
                                 want.texel_x, want.texel_y, field, got_v, want_v));
        endtask

        task check_texel(t_out_item got);
            t_out_item want;
            if (texels_due.size() == 0) begin
                report($sformatf("texel (%0d,%0d) arrived with none due",
                                 got.texel_x, got.texel_y));
                return;
            end
            want = texels_due.pop_front();
            checked++;
            compare_field("x", got.texel_x, want.texel_x, want);
            compare_field("y", got.texel_y, want.texel_y, want);
            compare_field("red", got.red, want.red, want);
            compare_field("green", got.green, want.green, want);
            compare_field("blue", got.blue, want.blue, want);
            compare_field("alpha", got.alpha, want.alpha, want);
            compare_field("last_of_block", got.last_of_block, want.last_of_block, want);
            compare_field("last_of_image", got.last_of_image, want.last_of_image, want);
        endtask

    endclass

endpackage

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// DXT block texel decoder testbench
// Feeds compressed blocks through the decoder under a range of alpha modes
// and image sizes, with random idling on both handshakes, and checks every
// decoded texel against a scoreboard that decodes the same blocks itself.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import dxtd_pkg::*;
    import dxtd_scoreboard_pkg::*;

    // The register index and alpha mode that the package leaves unnamed.
    // Writes to the spare index must be ignored, and the spare mode must
    // decode as an opaque four-colour block.
    localparam logic [1:0] REG_SPARE  = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // The decoder is three registers deep, so a handful of cycles covers a
    // block that is still being walked but produces no texel.
    localparam int SETTLE_CYCLES = 8;
    // Length of the long receiver hold-off that makes the decoder back up.
    localparam int HOLD_CYCLES   = 150;
    // Cycles with no item moving on either side before the run is abandoned.
    // The longest quiet stretch in a correct run is the hold-off above.
    localparam int STALL_LIMIT   = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_bus;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_bus;

    texel_scoreboard sb;
    bit idle_on  = 1'b1;    // random idling on both sides
    bit hold_out = 1'b0;    // asks the receiver for one long hold-off
    int stall_cycles = 0;
    int settings_used = 0;

    dxt_block_texel_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_bus),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_bus)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Block builders
    // ------------------------------------------------------------------------

    function automatic t_in_item make_block(logic [15:0] c0, logic [15:0] c1,
                                            logic [31:0] indices, logic [63:0] alpha);
        t_in_item b;
        b.color_word = {indices, c1, c0};
        b.alpha_word = alpha;
        return b;
    endfunction

    // Interpolated alpha half whose texel indices run 0..7 twice, so every
    // entry of the alpha table is read.
    function automatic logic [63:0] alpha_ramp(logic [7:0] a0, logic [7:0] a1);
        logic [63:0] word;
        int i;
        word = {48'd0, a1, a0};
        for (i = 0; i < 16; i++) word[16 + 3 * i +: 3] = i[2:0];
        return word;
    endfunction

    // Random block. Equal end points get a nudge now and then, since they are
    // rare by chance yet select the three-colour palette in colour-key mode.
    function automatic t_in_item random_block();
        t_in_item b;
        b.color_word = {$urandom, $urandom};
        b.alpha_word = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) b.color_word[31:16] = b.color_word[15:0];
        if ($urandom_range(0, 9) == 0) b.alpha_word[15:8]  = b.alpha_word[7:0];
        return b;
    endfunction

    // Mostly small sides so that whole images get walked and edge blocks are
    // common; sometimes zero, and sometimes near or past the largest side.
    function automatic logic [12:0] random_side(bit narrow);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 13'd0;
        if (pick == 1 && !narrow) return 13'($urandom_range(4090, 8191));
        return 13'($urandom_range(1, 24));
    endfunction

    // Mode write with the unused upper data bits sometimes set.
    function automatic logic [12:0] random_mode_word();
        int pick;
        logic [1:0] m;
        pick = $urandom_range(0, 6);
        if (pick == 6)     m = MODE_SPARE;
        else if (pick < 2) m = MODE_DXT1;
        else if (pick < 4) m = MODE_DXT3;
        else               m = MODE_DXT5;
        if ($urandom_range(0, 3) == 0) return {11'($urandom_range(0, 2047)), m};
        return {11'd0, m};
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks. All of them start and end on a rising edge.
    // ------------------------------------------------------------------------

    // Writes the three registers back to back, and optionally a junk value
    // to the spare index. Only called while the decoder is idle.
    task automatic configure(input logic [12:0] mode_word, input logic [12:0] w,
                             input logic [12:0] h, input bit poke_spare);
        logic [1:0]  idx [4];
        logic [12:0] val [4];
        int n, k;
        idx[0] = REG_ALPHA_MODE;   val[0] = mode_word;
        idx[1] = REG_IMAGE_WIDTH;  val[1] = w;
        idx[2] = REG_IMAGE_HEIGHT; val[2] = h;
        idx[3] = REG_SPARE;        val[3] = 13'($urandom_range(0, 8191));
        n = poke_spare ? 4 : 3;
        for (k = 0; k < n; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            sb.note_config(idx[k], val[k]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Offers one block and returns once it is accepted, after a random idle spell at times.
    // Otherwise valid is left high, so a block that follows at once goes out with no gap.
    task automatic offer(input t_in_item blk);
        in_valid <= 1'b1;
        in_bus   <= blk;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.decode_block(blk);
        if (idle_on && $urandom_range(0, 9) < 3) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Stops offering, waits for every texel still due, then lets the decoder
    // finish any block that lies wholly outside the image.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready high by default, with random idle bursts and the one
    // long hold-off that the stimulus asks for.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int gap;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_out) begin
                hold_out = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else if (idle_on && rst_n && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 11);
                repeat (gap - 1) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor and stall counter. Values are read at the rising edge,
    // before any register or driver updates of that edge take effect.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_texel(out_bus);
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int n, random_blocks;
        logic [12:0] w;

        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ALPHA_MODE;
        cfg_data  = 13'd0;
        in_valid  = 1'b0;
        in_bus    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: colour-key mode on a 1x1 image, so every block
        // gives one texel that ends both the block and the image. The all
        // ones block has equal end points and index three everywhere, so it
        // must come out transparent black.
        offer(make_block(16'h0000, 16'h0000, 32'h0000_0000, 64'd0));
        offer(make_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '1));
        drain();

        // Colour-key mode on a 2x2 block image. Indices cycle 0,1,2,3 along
        // each row: four-colour palette, three-colour palette, equal end
        // points, and the colour extremes. The spare index is poked too.
        configure({11'd0, MODE_DXT1}, 13'd8, 13'd8, 1'b1);
        offer(make_block(16'hF81F, 16'h07E0, 32'hE4E4_E4E4, '1));
        offer(make_block(16'h001F, 16'hF800, 32'hE4E4_E4E4, 64'd0));
        offer(make_block(16'h8410, 16'h8410, 32'hE4E4_E4E4, {$urandom, $urandom}));
        offer(make_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, {$urandom, $urandom}));
        drain();

        // Explicit alpha on a 5x6 image: the right and bottom blocks are cut.
        configure({11'd0, MODE_DXT3}, 13'd5, 13'd6, 1'b0);
        offer(make_block(16'h1234, 16'hABCD, 32'h1B1B_1B1B, 64'h0123_4567_89AB_CDEF));
        offer(make_block(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, '1));
        offer(make_block(16'h0000, 16'hFFFF, 32'h0000_0000, 64'd0));
        offer(random_block());
        drain();

        // Interpolated alpha on a 7x4 image, both table shapes, equal end
        // points and the alpha extremes.
        configure({11'd0, MODE_DXT5}, 13'd7, 13'd4, 1'b0);
        offer(make_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, alpha_ramp(8'd255, 8'd0)));
        offer(make_block(16'h0000, 16'hFFFF, 32'h1B1B_1B1B, alpha_ramp(8'd0, 8'd255)));
        offer(make_block(16'h7BEF, 16'h7BEF, 32'hE4E4_E4E4, alpha_ramp(8'd128, 8'd128)));
        offer(make_block(16'h4208, 16'hC618, 32'hE4E4_E4E4, alpha_ramp(8'd200, 8'd50)));
        drain();

        // Spare mode with zero sides, which must count as a 1x1 image.
        configure({11'h7FF, MODE_SPARE}, 13'd0, 13'd0, 1'b0);
        offer(make_block(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, {$urandom, $urandom}));
        offer(random_block());
        drain();

        // Oversized width saturates; the height is exactly the largest side.
        // Three blocks move the position along the top row, then the image
        // shrinks to one block, so the next block lies outside it, gives no
        // texel and wraps the position back to the origin.
        configure({11'd0, MODE_DXT5}, 13'd8191, 13'd4096, 1'b0);
        repeat (3) offer(random_block());
        drain();
        configure({11'd0, MODE_DXT1}, 13'd4, 13'd4, 1'b0);
        repeat (2) offer(random_block());
        drain();

        // Back-pressure: the receiver holds off for a long stretch while
        // blocks keep coming, so the decoder fills up and stalls its input.
        // Then the sender waits for every texel before carrying on.
        configure({11'd0, MODE_DXT3}, 13'd16, 13'd16, 1'b0);
        idle_on  = 1'b0;
        hold_out = 1'b1;
        repeat (8) offer(random_block());
        idle_on  = 1'b1;
        drain();
        repeat (8) offer(random_block());
        drain();

        // Random settings, each followed by a short run of random blocks.
        // The block position carries over from one setting to the next.
        random_blocks = 0;
        while (random_blocks < 60) begin
            w = random_side(1'b0);
            configure(random_mode_word(), w, random_side(w > 13'd24),
                      $urandom_range(0, 7) == 0);
            n = $urandom_range(6, 14);
            repeat (n) offer(random_block());
            random_blocks += n;
            drain();
        end

        // Closing stretch at full rate on both sides.
        idle_on = 1'b0;
        configure(random_mode_word(), 13'($urandom_range(1, 16)),
                  13'($urandom_range(1, 12)), 1'b0);
        repeat (12) offer(random_block());
        drain();

        $display("decoded %0d blocks into %0d checked texels under %0d register settings,",
                 sb.blocks, sb.checked, settings_used);
        $display("covering all alpha modes, cut edge blocks, off-image blocks and stalls");
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
